### hdl/fp32_adder_defines.svh
// Assertion macros for the fp32 adder.
`ifndef FP32_ADDER_DEFINES_SVH
`define FP32_ADDER_DEFINES_SVH

// Same-cycle implication.
`define FPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fp32_adder check failed");

// Delayed implication.
`define FPA_ASSERT_LAT4(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##4 (cons)) \
    else $error("fp32_adder latency check failed");

`endif

### hdl/fpa_pkg.sv
// Constants, types and helpers for the fp32 adder.
`timescale 1ns / 1ps
package fpa_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7fffffff;
  localparam logic [31:0] POS_INF   = 32'h7f800000;
  localparam logic [31:0] NEG_INF   = 32'hff800000;
  localparam logic [7:0]  EXP_MAX   = 8'hff;
  localparam logic [7:0]  MAX_GAP   = 8'd26;
  localparam int          MW        = 27;

  typedef struct packed {
    logic          spec;
    logic [31:0]   spec_val;
    logic          sign;
    logic [7:0]    ex;
    logic [MW-1:0] ma;
    logic [MW-1:0] mb;
    logic [4:0]    gap;
    logic          sub;
  } s1_t;

  typedef struct packed {
    logic          spec;
    logic [31:0]   spec_val;
    logic          sign;
    logic [7:0]    ex;
    logic [MW:0]   sum;
    logic          sub;
  } s2_t;

  typedef struct packed {
    logic          spec;
    logic [31:0]   spec_val;
    logic          sign;
    logic [8:0]    ex;
    logic [MW-1:0] m;
  } s3_t;

  function automatic logic [4:0] lzc27(input logic [MW-1:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < MW; i++) begin
      if (v[i]) n = 5'(MW - 1 - i);
    end
    return n;
  endfunction

endpackage

### hdl/fp32_adder.sv
`timescale 1ns / 1ps
// Top level: four-stage pipelined IEEE-754 single-precision adder.
//
// Usage:
//   Drive in_operand_a / in_operand_b and pulse start. busy stays low, so
//   a transfer is accepted on every cycle start is high.
//   Stage 1 decodes special cases, orders operands by magnitude.
//   Stage 2 aligns the smaller mantissa (sticky jam) and adds/subtracts.
//   Stage 3 normalizes (leading-zero count and shift).
//   Stage 4 rounds to nearest even and packs.
//   Items pass each stage register in turn. Throughput: 1 per cycle,
//   set by the per-stage registers; no unit is shared between items.
//   out_valid is high for exactly one cycle with out_sum_bits; the result
//   must be taken then, the receiver cannot stall the pipe.
//   Reset (rst_n low, synchronous) clears all valid bits; in-flight items
//   are dropped. Subnormal inputs flush to zero; NaNs become 0x7fffffff.
`include "fp32_adder_defines.svh"
module fp32_adder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_sum_bits
);

  logic          v1_r, v2_r, v3_r, out_valid_r;
  fpa_pkg::s1_t  s1_nxt, s1_r;
  fpa_pkg::s2_t  s2_nxt, s2_r;
  fpa_pkg::s3_t  s3_nxt, s3_r;
  logic [31:0]   out_sum_bits_nxt, out_sum_bits_r;

  assign busy = 1'b0;

  // stage 1: decode and order
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, sml;
  logic [7:0]  gap8;
  always_comb begin
    a_nan = (in_operand_a[30:23] == fpa_pkg::EXP_MAX) && (in_operand_a[22:0] != 23'd0);
    b_nan = (in_operand_b[30:23] == fpa_pkg::EXP_MAX) && (in_operand_b[22:0] != 23'd0);
    a_inf = (in_operand_a[30:23] == fpa_pkg::EXP_MAX) && (in_operand_a[22:0] == 23'd0);
    b_inf = (in_operand_b[30:23] == fpa_pkg::EXP_MAX) && (in_operand_b[22:0] == 23'd0);
    swap  = in_operand_a[30:0] < in_operand_b[30:0];
    big   = swap ? in_operand_b : in_operand_a;
    sml   = swap ? in_operand_a : in_operand_b;
    gap8  = big[30:23] - sml[30:23];
    s1_nxt.spec     = 1'b1;
    s1_nxt.spec_val = 32'd0;
    if (a_nan || b_nan || (a_inf && b_inf && (in_operand_a[31] != in_operand_b[31]))) begin
      s1_nxt.spec_val = fpa_pkg::CANON_NAN;
    end else if ((a_inf && !in_operand_a[31]) || (b_inf && !in_operand_b[31])) begin
      s1_nxt.spec_val = fpa_pkg::POS_INF;
    end else if (a_inf || b_inf) begin
      s1_nxt.spec_val = fpa_pkg::NEG_INF;
    end else if (in_operand_a[30:23] == 8'd0 && in_operand_b[30:23] == 8'd0) begin
      s1_nxt.spec_val = 32'd0;
    end else if (in_operand_a[30:23] == 8'd0) begin
      s1_nxt.spec_val = in_operand_b;
    end else if (in_operand_b[30:23] == 8'd0) begin
      s1_nxt.spec_val = in_operand_a;
    end else if (gap8 > fpa_pkg::MAX_GAP) begin
      s1_nxt.spec_val = big;
    end else begin
      s1_nxt.spec = 1'b0;
    end
    s1_nxt.sign = big[31];
    s1_nxt.ex   = big[30:23];
    s1_nxt.ma   = {1'b1, big[22:0], 3'b000};
    s1_nxt.mb   = {1'b1, sml[22:0], 3'b000};
    s1_nxt.gap  = gap8[4:0];
    s1_nxt.sub  = big[31] != sml[31];
  end

  // stage 2: align and add
  logic [fpa_pkg::MW-1:0] mask, mbs;
  always_comb begin
    mask = (fpa_pkg::MW'(1) << s1_r.gap) - fpa_pkg::MW'(1);
    mbs  = s1_r.mb >> s1_r.gap;
    mbs[0] = mbs[0] | (|(s1_r.mb & mask));
    s2_nxt.spec     = s1_r.spec;
    s2_nxt.spec_val = s1_r.spec_val;
    s2_nxt.sign     = s1_r.sign;
    s2_nxt.ex       = s1_r.ex;
    s2_nxt.sub      = s1_r.sub;
    s2_nxt.sum      = s1_r.sub ? ({1'b0, s1_r.ma} - {1'b0, mbs})
                               : ({1'b0, s1_r.ma} + {1'b0, mbs});
  end

  // stage 3: normalize
  logic [4:0] lz;
  always_comb begin
    lz = fpa_pkg::lzc27(s2_r.sum[fpa_pkg::MW-1:0]);
    s3_nxt.spec     = s2_r.spec;
    s3_nxt.spec_val = s2_r.spec_val;
    s3_nxt.sign     = s2_r.sign;
    s3_nxt.ex       = {1'b0, s2_r.ex};
    s3_nxt.m        = s2_r.sum[fpa_pkg::MW-1:0];
    if (!s2_r.sub) begin
      if (s2_r.sum[fpa_pkg::MW]) begin
        s3_nxt.ex = {1'b0, s2_r.ex} + 9'd1;
        s3_nxt.m  = s2_r.sum[fpa_pkg::MW:1] | fpa_pkg::MW'(s2_r.sum[0]);
      end
    end else if (s2_r.sum == '0 || {1'b0, s2_r.ex} <= {4'd0, lz}) begin
      if (!s2_r.spec) begin
        s3_nxt.spec     = 1'b1;
        s3_nxt.spec_val = 32'd0;
      end
    end else begin
      s3_nxt.ex = {1'b0, s2_r.ex} - {4'd0, lz};
      s3_nxt.m  = s2_r.sum[fpa_pkg::MW-1:0] << lz;
    end
  end

  // stage 4: round and pack
  logic            rnd;
  logic [fpa_pkg::MW:0] mr;
  logic [8:0]      exr;
  logic [22:0]     man;
  always_comb begin
    rnd = s3_r.m[2] && (s3_r.m[3] || s3_r.m[1] || s3_r.m[0]);
    mr  = {1'b0, s3_r.m} + (rnd ? 28'd8 : 28'd0);
    exr = s3_r.ex;
    man = mr[25:3];
    if (mr[fpa_pkg::MW]) begin
      exr = s3_r.ex + 9'd1;
      man = mr[26:4];
    end
    if (s3_r.spec) begin
      out_sum_bits_nxt = s3_r.spec_val;
    end else if (exr >= 9'd255) begin
      out_sum_bits_nxt = {s3_r.sign, 31'd0} | fpa_pkg::POS_INF;
    end else if (exr == 9'd0) begin
      out_sum_bits_nxt = {s3_r.sign, 31'd0};
    end else begin
      out_sum_bits_nxt = {s3_r.sign, exr[7:0], man};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r           <= s1_nxt;
    s2_r           <= s2_nxt;
    s3_r           <= s3_nxt;
    out_sum_bits_r <= out_sum_bits_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_sum_bits = out_sum_bits_r;

  logic out_nan, out_denorm;
  assign out_nan    = (out_sum_bits[30:23] == fpa_pkg::EXP_MAX) && (out_sum_bits[22:0] != 23'd0);
  assign out_denorm = (out_sum_bits[30:23] == 8'd0) && (out_sum_bits[22:0] != 23'd0);

  `FPA_ASSERT_LAT4(a_latency, start && !busy, out_valid)
  `FPA_ASSERT_IMP(a_nan_canon, out_valid && out_nan, out_sum_bits == fpa_pkg::CANON_NAN)
  `FPA_ASSERT_IMP(a_no_subnormal, out_valid, !out_denorm)

endmodule

### tb/fp32_adder_tb.sv
// Self-checking testbench for the fp32_adder pipelined single-precision adder.
`timescale 1ns / 1ps
module fp32_adder_tb;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
  } addends_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic [31:0] out_sum_bits;

  addends_t    pending_q[$];
  logic [31:0] sum_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          gap_left = 0;
  bit          quiet = 1'b0;
  bit          all_sent = 1'b0;

  fp32_adder dut (.*);

  always #6 clk = ~clk;

  function automatic bit is_nan(logic [31:0] x);
    return x[30:23] == fpa_pkg::EXP_MAX && x[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] x);
    return x[30:23] == fpa_pkg::EXP_MAX && x[22:0] == 0;
  endfunction

  function automatic logic [31:0] fp_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    logic [8:0]  ex;
    logic [27:0] ma, mb;
    logic [7:0]  gap;
    if (is_nan(a) || is_nan(b)) return fpa_pkg::CANON_NAN;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return fpa_pkg::CANON_NAN;
    if ((is_inf(a) && !a[31]) || (is_inf(b) && !b[31])) return fpa_pkg::POS_INF;
    if (is_inf(a) || is_inf(b)) return fpa_pkg::NEG_INF;
    if (a[30:23] == 0 && b[30:23] == 0) return 32'h0;
    if (a[30:23] == 0) return b;
    if (b[30:23] == 0) return a;
    if (a[30:0] < b[30:0]) begin
      t = a; a = b; b = t;
    end
    ex = {1'b0, a[30:23]};
    gap = a[30:23] - b[30:23];
    if (gap > fpa_pkg::MAX_GAP) return a;
    ma = {2'b01, a[22:0], 3'b000};
    mb = {2'b01, b[22:0], 3'b000};
    for (int i = 0; i < gap; i++) mb = (mb >> 1) | (mb & 28'd1);
    if (a[31] == b[31]) begin
      ma = ma + mb;
      if (ma[27]) begin
        ex++;
        ma = (ma >> 1) | (ma & 28'd1);
      end
    end else begin
      ma = ma - mb;
      if (ma == 0) return 32'h0;
      while (!ma[26]) begin
        ex--;
        if (ex == 0) return 32'h0;
        ma = ma << 1;
      end
    end
    if (ma[2] && (ma[3] || ma[1] || ma[0])) begin
      ma = ma + 28'd8;
      if (ma[27]) begin
        ex++;
        ma = ma >> 1;
      end
    end
    if (ex >= 255) return {a[31], 31'h7f800000};
    if (ex == 0) return {a[31], 31'h0};
    return {a[31], ex[7:0], ma[25:3]};
  endfunction

  function automatic logic [31:0] rand_fp(int mode);
    logic [31:0] v;
    v = $urandom;
    case (mode)
      0: v[30:23] = 8'($urandom_range(100, 154));
      1: v[30:23] = 8'hff;
      2: v[30:23] = 8'h00;
      3: v[30:23] = $urandom_range(0, 1) ? 8'($urandom_range(1, 4))
                                         : 8'($urandom_range(250, 254));
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_pair(logic [31:0] a, logic [31:0] b);
    addends_t p;
    p.a = a;
    p.b = b;
    pending_q.push_back(p);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        sum_q.push_back(fp_sum(in_operand_a, in_operand_b));
        void'(pending_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        gap_left <= $urandom_range(1, 18) - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        start <= 1'b1;
        in_operand_a <= pending_q[0].a;
        in_operand_b <= pending_q[0].b;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [31:0] exp_sum;
    if (rst_n && out_valid) begin
      if (sum_q.size() == 0) begin
        $display("%0t: unexpected sum %h", $time, out_sum_bits);
        errors++;
      end else begin
        exp_sum = sum_q.pop_front();
        if (exp_sum !== out_sum_bits) begin
          $display("%0t: sum_bits expected %h actual %h", $time, exp_sum, out_sum_bits);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] a;
    int mode_a, mode_b;
    add_pair(32'h3f800000, 32'h3f800000);
    add_pair(32'h3f800000, 32'hbf800000);
    add_pair(32'h7fc00000, 32'h3f800000);
    add_pair(32'h3f800000, 32'h7f800001);
    add_pair(32'h7f800000, 32'hff800000);
    add_pair(32'h7f800000, 32'h3f800000);
    add_pair(32'hff800000, 32'hff800000);
    add_pair(32'h3f800000, 32'hff800000);
    add_pair(32'h80000001, 32'h00000005);
    add_pair(32'h007fffff, 32'hc0400000);
    add_pair(32'h40000000, 32'h807fffff);
    add_pair(32'h4b800000, 32'h33800000);
    add_pair(32'h4b800000, 32'hb4800000);
    add_pair(32'h7f7fffff, 32'h7f7fffff);
    add_pair(32'hff7fffff, 32'hf3800000);
    add_pair(32'h00800000, 32'h80800001);
    add_pair(32'h00800001, 32'h80800000);
    add_pair(32'h3f800001, 32'h33800000);
    add_pair(32'h3f800000, 32'h33800000);
    add_pair(32'h3fffffff, 32'h34000000);
    add_pair(32'hffffffff, 32'hffffffff);
    add_pair(32'h00000000, 32'h00000000);
    add_pair(32'h3f800000, 32'hbf7fffff);
    for (int i = 0; i < 880; i++) begin
      mode_a = $urandom_range(0, 9);
      mode_b = $urandom_range(0, 9);
      mode_a = mode_a < 6 ? 0 : mode_a - 5;
      mode_b = mode_b < 6 ? 0 : mode_b - 5;
      a = rand_fp(mode_a);
      if ($urandom_range(0, 3) == 0)
        add_pair(a, {~a[31], a[30:23], a[22:0] ^ 23'($urandom_range(0, 7))});
      else add_pair(a, rand_fp(mode_b));
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() < 60);
    quiet = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk);
    wait (sum_q.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && sum_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
